### rtl/dpnmf_pkg.sv
// Shared types, constants and helper functions of the dark pixel neighbour mean filter.
`default_nettype none

package dpnmf_pkg;

  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int HEIGHT_MIN     = 3;

  localparam int PIX_W       = 8;
  localparam int CLEN_W      = 11;
  localparam int LIMIT_W     = 4;
  localparam int DARK_W      = 4;
  localparam int NEIGHBORS   = 8;
  localparam int NB_PAIRS    = 4;
  localparam int NB_CNT_W    = 3;
  localparam int SUM_W       = 11;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 14;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam int COLUMN_LENGTH_RESET = 28;
  localparam int DARK_LEVEL_RESET    = 5;
  localparam int DARK_LIMIT_RESET    = 5;

  typedef enum logic [1:0] {
    REG_COLUMN_LENGTH = 2'd0,
    REG_DARK_LEVEL    = 2'd1,
    REG_DARK_LIMIT    = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             flush;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             replaced;
    logic             frame_end;
  } result_t;

  typedef struct packed {
    logic [CLEN_W-1:0]  column_length;
    logic [PIX_W-1:0]   dark_level;
    logic [LIMIT_W-1:0] dark_neighbor_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_NEIGH,
    ST_DIVIDE,
    ST_OUTPUT
  } state_t;

  typedef struct packed {
    logic take;
    logic check;
    logic nb_step;
    logic divide;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic emit_now;
    logic eligible;
    logic nb_done;
    logic out_free;
  } status_t;

  // Rounded-up reciprocal of the divisor scaled by two to the RECIP_SHIFT.
  function automatic logic [RECIP_W-1:0] recip(input logic [DARK_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      4'd1:    r = 15'd16384;
      4'd2:    r = 15'd8192;
      4'd3:    r = 15'd5462;
      4'd4:    r = 15'd4096;
      4'd5:    r = 15'd3277;
      4'd6:    r = 15'd2731;
      4'd7:    r = 15'd2341;
      4'd8:    r = 15'd2048;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/dpnmf_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module dpnmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

### rtl/dpnmf_regs.sv
// APB-style configuration registers of the filter.
`default_nettype none

module dpnmf_regs import dpnmf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output cfg_t              cfg,
  output logic              restart
);

  logic       wr;
  logic [1:0] index;

  assign wr      = psel && penable && pwrite;
  assign index   = paddr[3:2];
  assign restart = wr && (index == REG_COLUMN_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.column_length       <= CLEN_W'(COLUMN_LENGTH_RESET);
      cfg.dark_level          <= PIX_W'(DARK_LEVEL_RESET);
      cfg.dark_neighbor_limit <= LIMIT_W'(DARK_LIMIT_RESET);
    end else if (wr) begin
      case (index)
        REG_COLUMN_LENGTH: cfg.column_length       <= pwdata[CLEN_W-1:0];
        REG_DARK_LEVEL:    cfg.dark_level          <= pwdata[PIX_W-1:0];
        REG_DARK_LIMIT:    cfg.dark_neighbor_limit <= pwdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_COLUMN_LENGTH: prdata = APB_DW'(cfg.column_length);
      REG_DARK_LEVEL:    prdata = APB_DW'(cfg.dark_level);
      REG_DARK_LIMIT:    prdata = APB_DW'(cfg.dark_neighbor_limit);
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/dpnmf_ctrl.sv
// Controller state machine that sequences each request through the datapath.
`default_nettype none

module dpnmf_ctrl import dpnmf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  status_t status,
  output logic    item_ready,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid && status.emit_now) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = status.eligible ? ST_NEIGH : ST_OUTPUT;
      end
      ST_NEIGH: begin
        if (status.nb_done) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        state_next = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        cmd.take   = item_valid;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
      end
      ST_NEIGH: begin
        cmd.nb_step = 1'b1;
      end
      ST_DIVIDE: begin
        cmd.divide = 1'b1;
      end
      ST_OUTPUT: begin
        cmd.load = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/dpnmf_datapath.sv
// Datapath: window store, frame counters, neighbour accumulation, divide and output register.
`default_nettype none

module dpnmf_datapath import dpnmf_pkg::*; #(
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    restart,
  input  item_t   item,
  input  cmd_t    cmd,
  output status_t status,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int AW    = $clog2(3 * MAX_HEIGHT);
  localparam int HW    = $clog2(MAX_HEIGHT + 3);
  localparam int WW    = (HW > CLEN_W ? HW : CLEN_W) + 1;
  localparam int DEPTH = 3 * MAX_HEIGHT;

  localparam logic [AW-1:0] BASE1 = AW'(MAX_HEIGHT);
  localparam logic [AW-1:0] BASE2 = AW'(2 * MAX_HEIGHT);

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [1:0] slot_dec(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic [AW-1:0] addr(input logic [1:0] s, input logic [RW-1:0] r);
    logic [AW-1:0] base;
    case (s)
      2'd0:    base = '0;
      2'd1:    base = BASE1;
      default: base = BASE2;
    endcase
    return base + AW'(r);
  endfunction

  logic [WW-1:0] len_ext;
  logic [WW-1:0] h;

  logic [RW-1:0]       row_pos;
  logic [1:0]          in_slot;
  logic [RW-1:0]       out_row;
  logic [1:0]          out_slot;
  logic                not_first;
  logic                draining;
  logic                may_filter;
  logic [HW-1:0]       pending;
  logic [NB_CNT_W-1:0] nb_cnt;

  logic [PIX_W-1:0]  center;
  logic [DARK_W-1:0] dark;
  logic [SUM_W-1:0]  sum;
  logic              replace;
  logic [PROD_W-1:0] prod;

  logic              stream_item;
  logic              frame_end;
  logic [PIX_W-1:0]  quotient;
  logic [LIMIT_W-1:0] limit;
  logic [RW-1:0]     row_up;
  logic [RW-1:0]     row_dn;
  logic [1:0]        prev_slot;
  logic [1:0]        next_slot;
  logic [AW-1:0]     center_addr;
  logic [AW-1:0]     in_addr;
  logic [AW-1:0]     nb_addr_a;
  logic [AW-1:0]     nb_addr_b;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [PIX_W-1:0]  wdata;
  logic [AW-1:0]     raddr_a;
  logic [PIX_W-1:0]  rdata_a;
  logic [PIX_W-1:0]  rdata_b;
  logic              a_dark;
  logic              b_dark;

  assign len_ext = WW'(cfg.column_length);

  always_comb begin
    if (len_ext < WW'(HEIGHT_MIN)) begin
      h = WW'(HEIGHT_MIN);
    end else if (len_ext > WW'(MAX_HEIGHT)) begin
      h = WW'(MAX_HEIGHT);
    end else begin
      h = len_ext;
    end
  end

  assign stream_item = !draining && !item.flush;
  assign frame_end   = (pending == HW'(1));
  assign quotient    = prod[RECIP_SHIFT +: PIX_W];
  assign limit       = (cfg.dark_neighbor_limit > LIMIT_W'(NEIGHBORS)) ?
                       LIMIT_W'(NEIGHBORS) : cfg.dark_neighbor_limit;

  assign row_up      = out_row - RW'(1);
  assign row_dn      = out_row + RW'(1);
  assign prev_slot   = slot_dec(out_slot);
  assign next_slot   = slot_inc(out_slot);
  assign center_addr = addr(out_slot, out_row);
  assign in_addr     = addr(in_slot, row_pos);

  always_comb begin
    case (nb_cnt[1:0])
      2'd0: begin
        nb_addr_a = addr(prev_slot, row_up);
        nb_addr_b = addr(prev_slot, out_row);
      end
      2'd1: begin
        nb_addr_a = addr(prev_slot, row_dn);
        nb_addr_b = addr(out_slot, row_up);
      end
      2'd2: begin
        nb_addr_a = addr(out_slot, row_dn);
        nb_addr_b = addr(next_slot, row_up);
      end
      default: begin
        nb_addr_a = addr(next_slot, out_row);
        nb_addr_b = addr(next_slot, row_dn);
      end
    endcase
  end

  assign raddr_a = cmd.nb_step ? nb_addr_a : center_addr;
  assign we      = (cmd.take && stream_item) || (cmd.load && replace);
  assign waddr   = cmd.take ? in_addr : center_addr;
  assign wdata   = cmd.take ? item.pixel : quotient;

  dpnmf_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .rdata_a(rdata_a),
    .raddr_b(nb_addr_b),
    .rdata_b(rdata_b)
  );

  assign a_dark = (rdata_a <= cfg.dark_level);
  assign b_dark = (rdata_b <= cfg.dark_level);

  assign status.emit_now = stream_item ? ((WW'(pending) + WW'(1)) >= (h + WW'(2))) :
                           (pending != '0);
  assign status.eligible = may_filter && not_first && (out_row != '0) &&
                           ((WW'(out_row) + WW'(2)) <= h) &&
                           (rdata_a <= cfg.dark_level);
  assign status.nb_done  = (nb_cnt == NB_CNT_W'(NB_PAIRS));
  assign status.out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row_pos    <= '0;
      in_slot    <= '0;
      out_row    <= '0;
      out_slot   <= '0;
      not_first  <= 1'b0;
      draining   <= 1'b0;
      may_filter <= 1'b0;
      pending    <= '0;
      nb_cnt     <= '0;
    end else begin
      if (cmd.take) begin
        may_filter <= stream_item;
        if (stream_item) begin
          pending <= pending + HW'(1);
          if ((WW'(row_pos) + WW'(1)) >= h) begin
            row_pos <= '0;
            in_slot <= slot_inc(in_slot);
          end else begin
            row_pos <= row_pos + RW'(1);
          end
        end else begin
          draining <= (pending != '0);
        end
      end
      if (cmd.check) begin
        nb_cnt <= '0;
      end else if (cmd.nb_step) begin
        nb_cnt <= nb_cnt + NB_CNT_W'(1);
      end
      if (cmd.load) begin
        if (frame_end) begin
          row_pos   <= '0;
          in_slot   <= '0;
          out_row   <= '0;
          out_slot  <= '0;
          not_first <= 1'b0;
          draining  <= 1'b0;
          pending   <= '0;
        end else begin
          pending <= pending - HW'(1);
          if ((WW'(out_row) + WW'(1)) >= h) begin
            out_row   <= '0;
            out_slot  <= slot_inc(out_slot);
            not_first <= 1'b1;
          end else begin
            out_row <= out_row + RW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      center  <= rdata_a;
      dark    <= '0;
      sum     <= '0;
      replace <= 1'b0;
    end else if (cmd.nb_step && (nb_cnt != '0)) begin
      dark <= dark + DARK_W'(a_dark) + DARK_W'(b_dark);
      sum  <= sum + (a_dark ? '0 : SUM_W'(rdata_a)) + (b_dark ? '0 : SUM_W'(rdata_b));
    end else if (cmd.divide) begin
      replace <= (dark < limit);
      prod    <= PROD_W'(sum) * PROD_W'(recip(DARK_W'(NEIGHBORS) - dark));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result.value     <= replace ? quotient : center;
      result.replaced  <= replace;
      result.frame_end <= frame_end;
    end
  end

endmodule

`default_nettype wire

### rtl/dark_pixel_neighbor_mean_filter.sv
// Top level of the dark pixel neighbour mean filter over a column-major gray stream.
// A request that yields no result is only taken; a pixel that passes through is checked and
// loaded. A filtered pixel also takes four paired reads of the window store, a multiply by a
// reciprocal and the output load. A result follows its pixel by the clamped column_length + 1
// requests. Reset is synchronous and clears the frame counters and the output valid flag; the
// registers return to their defaults, and the window store is left as it is.
`default_nettype none

module dark_pixel_neighbor_mean_filter import dpnmf_pkg::*; #(
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  input  logic              item_valid,
  output logic              item_ready,
  input  item_t             item,
  output logic              result_valid,
  input  logic              result_ready,
  output result_t           result
);

  cfg_t    cfg;
  logic    restart;
  cmd_t    cmd;
  status_t status;

  assign pready = 1'b1;

  dpnmf_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .cfg    (cfg),
    .restart(restart)
  );

  dpnmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .status    (status),
    .item_ready(item_ready),
    .cmd       (cmd)
  );

  dpnmf_datapath #(
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .restart     (restart),
    .item        (item),
    .cmd         (cmd),
    .status      (status),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

`default_nettype wire

### rtl/dpnmf_checker.sv
// Port-level checker of the filter and its bind to the top level.
`default_nettype none

module dpnmf_checker import dpnmf_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [APB_AW-1:0] paddr,
  input logic [APB_DW-1:0] pwdata,
  input logic [APB_DW-1:0] prdata,
  input logic              pready,
  input logic              item_valid,
  input logic              item_ready,
  input item_t             item,
  input logic              result_valid,
  input logic              result_ready,
  input result_t           result
);

  a_pready_high: assert property (@(posedge clk) pready)
    else $error("pready dropped");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_end_not_filtered: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_end |-> !result.replaced)
    else $error("frame end result marked as replaced");

endmodule

bind dark_pixel_neighbor_mean_filter dpnmf_checker u_checker (.*);

`default_nettype wire
